### hdl/sorted_list_engine_top_defines.svh
// ----------------------------------------------------------------------------
// sorted_list_engine_top_defines.svh
// Assertion macros used by the checker file sle_checker.
// ----------------------------------------------------------------------------
`ifndef SORTED_LIST_ENGINE_TOP_DEFINES_SVH
`define SORTED_LIST_ENGINE_TOP_DEFINES_SVH

// same-cycle implication, clocked on clk, idle during rst
`define SLE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sorted list engine check failed");

// next-cycle implication, clocked on clk, idle during rst
`define SLE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorted list engine check failed");

`endif

### hdl/sle_pkg.sv
// ----------------------------------------------------------------------------
// sle_pkg
// Request and status codes and the link types of the sorted list cell chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sle_pkg;

  localparam logic [1:0] MODE_INS = 2'd0;
  localparam logic [1:0] MODE_POP = 2'd1;
  localparam logic [1:0] MODE_DEL = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_MISS  = 2'd3;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] value;
  } op_t;

  // handed from a cell to the cell on its right
  typedef struct packed {
    logic signed [31:0] val;
    logic               vld;
    logic               take;
    logic               fnd;
  } left_t;

  // handed from a cell to the cell on its left, also a cell's next content
  typedef struct packed {
    logic signed [31:0] val;
    logic               vld;
  } slot_t;

endpackage

### hdl/sle_cell.sv
// ----------------------------------------------------------------------------
// sle_cell
// One slot of the sorted list: compares against the request, shifts right on
// insert and left on removal.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sle_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  sle_pkg::op_t    op,
  input  sle_pkg::left_t  from_left,
  output sle_pkg::left_t  to_right,
  input  sle_pkg::slot_t  from_right,
  output sle_pkg::slot_t  to_left,
  output sle_pkg::slot_t  nxt
);

  logic signed [31:0] val;
  logic               vld;
  logic               take;
  logic               hit;
  logic               shift_left;
  sle_pkg::slot_t     slot_next;

  assign take       = !vld || (op.value <= val);
  assign hit        = vld && (val == op.value);
  assign shift_left = (op.mode == sle_pkg::MODE_POP) || from_left.fnd || hit;

  assign to_right = '{val: val, vld: vld, take: take, fnd: shift_left};
  assign to_left  = '{val: val, vld: vld};

  always_comb begin
    slot_next = '{val: val, vld: vld};
    case (op.mode)
      sle_pkg::MODE_INS: begin
        if (from_left.take) begin
          slot_next = '{val: from_left.val, vld: from_left.vld};
        end else if (take) begin
          slot_next = '{val: op.value, vld: 1'b1};
        end
      end
      sle_pkg::MODE_POP, sle_pkg::MODE_DEL: begin
        if (shift_left) begin
          slot_next = from_right;
        end
      end
      default: begin
        slot_next = '{val: val, vld: vld};
      end
    endcase
  end

  assign nxt = slot_next;

  always_ff @(posedge clk) begin
    if (en) begin
      val <= slot_next.val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= slot_next.vld;
    end
  end

endmodule

### hdl/sorted_list_engine_top.sv
// ----------------------------------------------------------------------------
// sorted_list_engine_top
// Sorted list of signed 32-bit words held in a chain of compare-and-shift
// cells, with insert, pop-smallest and remove-by-key requests.
// ----------------------------------------------------------------------------
// Each request word is taken and its result word is registered at
// the edge that takes it and offered from the following cycle, so the block
// sustains one word per cycle; in_ready drops only while a finished result
// waits for out_ready. The cell chain settles an insert or removal
// combinationally before that edge; a remove-by-key search ripples its match
// flag through all DEPTH cells, which sets the clock period for deep lists.
// Status: 0 done, 1 full (insert dropped), 2 empty, 3 key not found.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_list_engine_top #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         mode,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] smallest,
  output logic [4:0]         count,
  output logic [1:0]         status
);

  localparam int CW = $clog2(DEPTH + 1);

  logic                accept;
  logic                en;
  logic                full;
  logic                empty;
  logic                found;
  logic [CW-1:0]       cnt;
  logic [CW-1:0]       cnt_next;
  logic [1:0]          status_next;
  sle_pkg::op_t        op;
  sle_pkg::slot_t      head;
  sle_pkg::left_t      lnk [DEPTH+1];
  sle_pkg::slot_t      rgt [DEPTH+1];
  sle_pkg::slot_t      nxt [DEPTH];

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign op       = '{mode: mode, value: value};

  assign full  = (cnt == CW'(DEPTH));
  assign empty = (cnt == '0);
  assign found = lnk[DEPTH].fnd;

  // hold the list on an insert into a full list
  assign en = accept && !((mode == sle_pkg::MODE_INS) && full);

  assign lnk[0]     = '{val: '0, vld: 1'b1, take: 1'b0, fnd: 1'b0};
  assign rgt[DEPTH] = '{val: '0, vld: 1'b0};

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    sle_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .en         (en),
      .op         (op),
      .from_left  (lnk[i]),
      .to_right   (lnk[i+1]),
      .from_right (rgt[i+1]),
      .to_left    (rgt[i]),
      .nxt        (nxt[i])
    );
  end

  assign head = en ? nxt[0] : rgt[0];

  always_comb begin
    cnt_next    = cnt;
    status_next = sle_pkg::ST_OK;
    case (mode)
      sle_pkg::MODE_INS: begin
        if (full) begin
          status_next = sle_pkg::ST_FULL;
        end else begin
          cnt_next = cnt + CW'(1);
        end
      end
      sle_pkg::MODE_POP: begin
        if (empty) begin
          status_next = sle_pkg::ST_EMPTY;
        end else begin
          cnt_next = cnt - CW'(1);
        end
      end
      sle_pkg::MODE_DEL: begin
        if (empty) begin
          status_next = sle_pkg::ST_EMPTY;
        end else if (!found) begin
          status_next = sle_pkg::ST_MISS;
        end else begin
          cnt_next = cnt - CW'(1);
        end
      end
      default: begin
        cnt_next = cnt;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        cnt       <= cnt_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      smallest <= head.vld ? head.val : 32'sd0;
      count    <= 5'(cnt_next);
      status   <= status_next;
    end
  end

endmodule

### hdl/sle_checker.sv
// ----------------------------------------------------------------------------
// sle_checker
// Port-level checks on the sorted list engine, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sorted_list_engine_top_defines.svh"

module sle_checker #(
  parameter int DEPTH = 16
) (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] smallest,
  input logic [4:0]         count,
  input logic [1:0]         status
);

  `SLE_ASSERT_NXT(a_result_follows, in_valid && in_ready, out_valid)
  `SLE_ASSERT_NXT(a_result_holds, out_valid && !out_ready, out_valid && $stable(smallest))
  `SLE_ASSERT_NOW(a_empty_zero, out_valid && status == sle_pkg::ST_EMPTY, count == 5'd0 && smallest == 32'sd0)
  `SLE_ASSERT_NOW(a_full_count, out_valid && status == sle_pkg::ST_FULL, count == 5'(DEPTH))

endmodule

bind sorted_list_engine_top sle_checker #(.DEPTH(DEPTH)) u_sle_checker (.*);
